/* hdl/sdmg_pkg.sv */
// Shared types and constants for the step/dir move generator.
// No dependencies; used by sdmg_step and step_dir_move_generator.
package sdmg_pkg;

	// Position width of the motion controller; positions wider than 32 bits
	// still arrive on 32-bit ports, so only the low bits up to 32 count.
	localparam int POS_WIDTH = 32;
	localparam int POS_EFF   = (POS_WIDTH < 32) ? POS_WIDTH : 32;

	localparam int CFG_IDX_W = 1;

	// Command codes carried in the kind field
	typedef enum logic [2:0] {
		KIND_TICK   = 3'd0,
		KIND_MOVE   = 3'd1,
		KIND_STOP   = 3'd2,
		KIND_LIMIT  = 3'd3,
		KIND_ENABLE = 3'd4,
		KIND_CLEAR  = 3'd5
	} kind_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_PERIOD  = 1'd0,
		CFG_LIMITS_ARMED = 1'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        elapsed_us;
		logic signed [31:0] move_target;
		logic signed [31:0] present_position;
		logic               enable_value;
	} item_t;

	typedef struct packed {
		logic [31:0] time_acc;
		logic [31:0] step_count;
		logic        direction;
		logic        busy;
		logic        enabled;
		logic        limit_latched;
	} state_t;

	typedef struct packed {
		logic        moving;
		logic        step_strobe;
		logic        dir_out;
		logic        done_res;
		logic        limit_event;
		logic        limit_flag;
		logic [31:0] steps_left;
	} result_t;

endpackage

/* hdl/sdmg_step.sv */
// Next-state and result logic for one command beat of the move generator.
// Depends on sdmg_pkg for the beat, state and result structs.
module sdmg_step (
	input  sdmg_pkg::item_t   item,
	input  sdmg_pkg::state_t  cur,
	input  logic [31:0]       step_period_us,
	input  logic              limits_armed,
	output sdmg_pkg::state_t  nxt,
	output sdmg_pkg::result_t res
);
	import sdmg_pkg::*;

	logic [32:0]         acc_sum;
	logic [31:0]         acc_sat;
	logic                period_hit;
	logic signed [32:0]  tgt_x;
	logic signed [32:0]  pos_x;
	logic signed [32:0]  diff;
	logic [32:0]         mag;
	logic [31:0]         mag_sat;
	logic [31:0]         cnt_dec;
	logic                pulse;
	logic                done;
	logic                lim_ev;

	// Saturating accumulator add and period compare
	assign acc_sum    = {1'b0, cur.time_acc} + {1'b0, item.elapsed_us};
	assign acc_sat    = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
	assign period_hit = (acc_sat >= step_period_us);
	assign cnt_dec    = cur.step_count - 32'd1;

	// Exact move distance in 33 bits, magnitude saturated to 32 bits
	assign tgt_x   = 33'(signed'(item.move_target[POS_EFF-1:0]));
	assign pos_x   = 33'(signed'(item.present_position[POS_EFF-1:0]));
	assign diff    = tgt_x - pos_x;
	assign mag     = diff[32] ? (33'd0 - diff) : diff;
	assign mag_sat = mag[32] ? 32'hFFFF_FFFF : mag[31:0];

	// Apply the command to the state
	always_comb begin
		nxt    = cur;
		pulse  = 1'b0;
		done   = 1'b0;
		lim_ev = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				if (cur.enabled && cur.busy) begin
					nxt.time_acc = acc_sat;
					if (period_hit) begin
						nxt.time_acc = acc_sat - step_period_us;
						if (cur.step_count != 32'd0) begin
							pulse          = 1'b1;
							nxt.step_count = cnt_dec;
						end
						if (cur.step_count == 32'd0 || cnt_dec == 32'd0) begin
							nxt.busy = 1'b0;
							done     = 1'b1;
						end
					end
				end
			end
			KIND_MOVE: begin
				nxt.direction     = ~diff[32];
				nxt.step_count    = mag_sat;
				nxt.busy          = 1'b1;
				nxt.limit_latched = 1'b0;
			end
			KIND_STOP: begin
				nxt.busy       = 1'b0;
				nxt.step_count = 32'd0;
			end
			KIND_LIMIT: begin
				if (limits_armed) begin
					nxt.limit_latched = 1'b1;
					nxt.busy          = 1'b0;
					lim_ev            = 1'b1;
				end
			end
			KIND_ENABLE: begin
				nxt.enabled = item.enable_value;
			end
			KIND_CLEAR: begin
				nxt.limit_latched = 1'b0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// Report the state after the beat
	assign res.moving      = nxt.busy;
	assign res.step_strobe = pulse;
	assign res.dir_out     = nxt.direction;
	assign res.done_res    = done;
	assign res.limit_event = lim_ev;
	assign res.limit_flag  = nxt.limit_latched;
	assign res.steps_left  = nxt.step_count;

endmodule

/* hdl/step_dir_move_generator.sv */
// Top level of the step/dir move generator: input stage, state, result stage.
// Depends on sdmg_pkg and sdmg_step.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | kind, elapsed_us, move_target/present_position,
//          |                      | enable_value
//  out     | out_valid/out_stall  | moving, step_strobe, dir_out, done_res, limit_*,
//          |                      | steps_left
//  cfg     | cfg_we               | cfg_index, cfg_data (step period, limits armed)
//
// One beat per clock while out_stall is low; a taken beat passes the input register and
// then the result register before its result is offered.
// The state update for a beat is one 33-bit add, compare and subtract.
// arst_n clears the state, both config registers and both valid flags.
// A stalled result holds the input register; in_stall rises only when both
// stages are full and out_stall is high.
module step_dir_move_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sdmg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   kind,
	input  logic [31:0]                  elapsed_us,
	input  logic signed [31:0]           move_target,
	input  logic signed [31:0]           present_position,
	input  logic                         enable_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         moving,
	output logic                         step_strobe,
	output logic                         dir_out,
	output logic                         done_res,
	output logic                         limit_event,
	output logic                         limit_flag,
	output logic [31:0]                  steps_left
);
	import sdmg_pkg::*;

	logic [31:0] period_q;
	logic        armed_q;
	state_t      state_q;
	state_t      state_nxt;
	item_t       item_s1;
	logic        vld_s1;
	result_t     res_c;
	result_t     res_s2;
	logic        vld_s2;
	logic        adv;
	logic        take;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			armed_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP_PERIOD:  period_q <= cfg_data;
				CFG_LIMITS_ARMED: armed_q  <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Handshake: advance the input stage when the result stage can take it
	assign adv      = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv;
	assign take     = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{kind: kind, elapsed_us: elapsed_us,
				move_target: move_target,
				present_position: present_position,
				enable_value: enable_value};
		end
	end

	sdmg_step u_step (
		.item           (item_s1),
		.cur            (state_q),
		.step_period_us (period_q),
		.limits_armed   (armed_q),
		.nxt            (state_nxt),
		.res            (res_c)
	);

	// Commit the state as the beat moves into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid   = vld_s2;
	assign moving      = res_s2.moving;
	assign step_strobe = res_s2.step_strobe;
	assign dir_out     = res_s2.dir_out;
	assign done_res    = res_s2.done_res;
	assign limit_event = res_s2.limit_event;
	assign limit_flag  = res_s2.limit_flag;
	assign steps_left  = res_s2.steps_left;

	// State moves only with a beat
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("state changed without a beat");

	// A completed move leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_c.done_res) |=> !state_q.busy)
		else $error("done without clearing busy");

	// A step pulse needs an enabled, busy tick
	a_pulse_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_c.step_strobe) |->
		(item_s1.kind == KIND_TICK && state_q.enabled && state_q.busy))
		else $error("step pulse outside an active tick");

	// A taken limit event stops motion and sets the flag
	a_limit_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_c.limit_event) |=> (state_q.limit_latched && !state_q.busy))
		else $error("limit event did not stop motion");

	// A full input stage is never dropped while results are stalled
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && out_stall) |=> vld_s1)
		else $error("input stage lost a beat");

endmodule
